/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file of the encoder
// no dependencies; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define TSRE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define TSRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tsre_pkg.sv */
// types and constants of the transparent sprite run-length encoder
// no dependencies
`default_nettype none

package tsre_pkg;

   // result item kinds
   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_SKIP    = 2'd1;
   localparam logic [1:0] KIND_COPY    = 2'd2;
   localparam logic [1:0] KIND_HEADER  = 2'd3;

   // configuration register indexes
   localparam int         CSR_IDX_W          = 2;
   localparam int         CSR_DATA_W         = 16;
   localparam logic [1:0] CSR_TRANSPARENT    = 2'd0;
   localparam logic [1:0] CSR_LINE_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT   = 2'd2;

   // field widths
   localparam int PIXEL_W  = 8;
   localparam int LWIDTH_W = 13;
   localparam int HEIGHT_W = 16;
   localparam int BYTES_W  = 15;
   localparam int CMP_W    = 17;

   // line layout
   localparam logic [BYTES_W-1:0] HEADER_BYTES = 15'd4;
   localparam logic [BYTES_W-1:0] RECORD_BYTES = 15'd4;

   // result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;
   localparam int MAX_PUSH    = 4;
   localparam int PUSH_IDX_W  = 2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTES_W-1:0] value;
      logic [BYTES_W-1:0] offset;
      logic               line_done;
      logic               frame_done;
   } item_type;

   // items written into the queue in one cycle, packed from slot 0 up
   typedef struct packed {
      logic [QUEUE_AW-1:0]       count;
      item_type [MAX_PUSH-1:0]   slot;
   } push_type;

endpackage

`default_nettype wire

/* rtl/core/tsre_result_queue.sv */
// result queue: takes up to four items a cycle, gives one a cycle while out_ready is high
// depends on tsre_pkg
`default_nettype none

module tsre_result_queue
   import tsre_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);

   item_type [QUEUE_DEPTH-1:0] q_ff;
   logic [QUEUE_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]          count_ff, count_in;
   logic [QUEUE_DEPTH-1:0]     slot_we;
   item_type [QUEUE_DEPTH-1:0] slot_wdata;
   logic [QUEUE_AW-1:0]        slot_rel [QUEUE_DEPTH];
   logic                       pop;

   // head of the queue and free space for a full push
   assign out_valid = (count_ff != '0);
   assign out_item  = q_ff[rd_ptr_ff];
   assign room      = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_PUSH));
   assign pop       = out_valid && out_ready;

   // each entry checks whether it falls inside this cycle's push window
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_rel[i]   = QUEUE_AW'(i) - wr_ptr_ff;
         slot_we[i]    = (slot_rel[i] < push.count);
         slot_wdata[i] = push.slot[slot_rel[i][PUSH_IDX_W-1:0]];
      end
   end

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (slot_we[i]) begin
            q_ff[i] <= slot_wdata[i];
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/transparent_sprite_rle_encoder_core.sv */
// Transparent sprite run-length encoder, top level.
// The first result of a pixel passes the input register and the result queue before it is
// offered. A pixel enters every cycle while each yields at most one result and the result
// port is ready; the results of one pixel leave one at a time on the single result port
// (a copy pixel that ends a skip run yields at least two). Reset is synchronous and active high: it clears run state,
// counters and the queue, and sets transparent value 0, line width 8 and image height 1.
`default_nettype none

module transparent_sprite_rle_encoder_core
   import tsre_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 4096
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pixel stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] pixel_value
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,   // [14:0] item_value, [29:15] byte_offset
   output logic                       rsp_tlast,   // line_done
   output logic [2:0]                 rsp_tuser,   // [1:0] item_kind, [2] frame_done
   // configuration writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_LINE_WIDTH + 1);

   // configuration
   logic [PIXEL_W-1:0]  transparent_ff;
   logic [LWIDTH_W-1:0] line_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;

   // input register
   logic               pix_valid_ff, pix_valid_in;
   logic [PIXEL_W-1:0] pix_ff;

   // run state
   logic [CW-1:0]       column_ff, column_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic                run_copy_ff, run_copy_in;
   logic [CW-1:0]       run_len_ff, run_len_in;
   logic [BYTES_W-1:0]  run_off_ff, run_off_in;
   logic [BYTES_W-1:0]  line_bytes_ff, line_bytes_in;

   // encode datapath
   logic                fire, room, req_xfer;
   logic                is_copy, col0, run_switch, line_end, last_line;
   logic [CMP_W-1:0]    eff_w, eff_h, col_next;
   logic                copy_a;
   logic [CW-1:0]       len_a;
   logic [BYTES_W-1:0]  off_a, bytes_a, bytes_b;
   logic [MAX_PUSH-1:0] cand_v;
   item_type [MAX_PUSH-1:0] cand;
   logic [QUEUE_AW-1:0] pos;
   push_type            push;
   item_type            head;

   // configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_ff  <= '0;
         line_width_ff   <= LWIDTH_W'(8);
         image_height_ff <= HEIGHT_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRANSPARENT:  transparent_ff  <= csr_wdata[PIXEL_W-1:0];
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata[LWIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: refills while the held pixel moves on
   assign fire         = pix_valid_ff && room;
   assign req_tready   = !pix_valid_ff || room;
   assign req_xfer     = req_tvalid && req_tready;
   assign pix_valid_in = req_xfer || (pix_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pix_ff <= req_tdata[PIXEL_W-1:0];
      end
   end

   // effective width and height limits
   always_comb begin
      eff_w = CMP_W'(line_width_ff);
      if (eff_w == '0) begin
         eff_w = CMP_W'(1);
      end
      if (eff_w > CMP_W'(MAX_LINE_WIDTH)) begin
         eff_w = CMP_W'(MAX_LINE_WIDTH);
      end
      eff_h = CMP_W'(image_height_ff);
      if (eff_h == '0) begin
         eff_h = CMP_W'(1);
      end
   end

   // run tracking for the held pixel
   always_comb begin
      is_copy    = (pix_ff != transparent_ff);
      col0       = (column_ff == '0);
      run_switch = !col0 && (is_copy != run_copy_ff);
      col_next   = CMP_W'(column_ff) + CMP_W'(1);
      line_end   = (col_next >= eff_w);
      last_line  = ((CMP_W'(row_ff) + CMP_W'(1)) >= eff_h);

      if (col0) begin
         copy_a  = is_copy;
         len_a   = CW'(1);
         off_a   = HEADER_BYTES;
         bytes_a = HEADER_BYTES + RECORD_BYTES;
      end else if (run_switch) begin
         copy_a  = is_copy;
         len_a   = CW'(1);
         off_a   = line_bytes_ff;
         bytes_a = line_bytes_ff + RECORD_BYTES;
      end else begin
         copy_a  = run_copy_ff;
         len_a   = run_len_ff + CW'(1);
         off_a   = run_off_ff;
         bytes_a = line_bytes_ff;
      end
      bytes_b = bytes_a + BYTES_W'(is_copy);
   end

   // candidate results in emit order: closed record, literal, final record, header
   always_comb begin
      cand_v[0]            = run_switch;
      cand[0].kind         = run_copy_ff ? KIND_COPY : KIND_SKIP;
      cand[0].value        = BYTES_W'(run_len_ff);
      cand[0].offset       = run_off_ff;
      cand[0].line_done    = 1'b0;
      cand[0].frame_done   = 1'b0;

      cand_v[1]            = is_copy;
      cand[1].kind         = KIND_LITERAL;
      cand[1].value        = BYTES_W'(pix_ff);
      cand[1].offset       = bytes_a;
      cand[1].line_done    = 1'b0;
      cand[1].frame_done   = 1'b0;

      cand_v[2]            = line_end;
      cand[2].kind         = copy_a ? KIND_COPY : KIND_SKIP;
      cand[2].value        = BYTES_W'(len_a);
      cand[2].offset       = off_a;
      cand[2].line_done    = 1'b0;
      cand[2].frame_done   = 1'b0;

      cand_v[3]            = line_end;
      cand[3].kind         = KIND_HEADER;
      cand[3].value        = bytes_b;
      cand[3].offset       = '0;
      cand[3].line_done    = 1'b1;
      cand[3].frame_done   = last_line;
   end

   // pack the present candidates from slot 0 up
   always_comb begin
      pos       = '0;
      push.slot = '0;
      for (int j = 0; j < MAX_PUSH; j++) begin
         if (cand_v[j]) begin
            push.slot[pos[PUSH_IDX_W-1:0]] = cand[j];
            pos = pos + QUEUE_AW'(1);
         end
      end
      push.count = fire ? pos : '0;
   end

   // next run state
   always_comb begin
      if (line_end) begin
         column_in     = '0;
         row_in        = last_line ? '0 : row_ff + HEIGHT_W'(1);
         run_copy_in   = 1'b0;
         run_len_in    = '0;
         run_off_in    = '0;
         line_bytes_in = '0;
      end else begin
         column_in     = col_next[CW-1:0];
         row_in        = row_ff;
         run_copy_in   = copy_a;
         run_len_in    = len_a;
         run_off_in    = off_a;
         line_bytes_in = bytes_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         run_copy_ff   <= 1'b0;
         run_len_ff    <= '0;
         run_off_ff    <= '0;
         line_bytes_ff <= '0;
      end else if (fire) begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         run_copy_ff   <= run_copy_in;
         run_len_ff    <= run_len_in;
         run_off_ff    <= run_off_in;
         line_bytes_ff <= line_bytes_in;
      end
   end

   // result queue feeding the result port
   tsre_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {2'b00, head.offset, head.value};
   assign rsp_tlast = head.line_done;
   assign rsp_tuser = {head.frame_done, head.kind};

endmodule

`default_nettype wire

/* rtl/core/tsre_checker.sv */
// port-level checks of the encoder result stream, bound to the top level
// depends on tsre_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tsre_checker
   import tsre_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [31:0]           rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [2:0]            rsp_tuser
);

   // a stalled result stays offered
   `TSRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // the line header and only the header ends a line, at offset zero
   `TSRE_ASSERT_IMPLY(a_header_last, clock, reset, rsp_tvalid, (rsp_tuser[1:0] == KIND_HEADER) == rsp_tlast, "tlast not on header")
   `TSRE_ASSERT_IMPLY(a_header_offset, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[29:15] == '0, "header offset not zero")

   // frame end is marked only on a line header
   `TSRE_ASSERT_IMPLY(a_frame_on_line, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tlast, "frame end without line end")

endmodule

bind transparent_sprite_rle_encoder_core tsre_checker u_tsre_checker (.*);

`default_nettype wire
